### rtl/core/assert_macros.svh
// Assertion macros shared by the point sort core.
// Included by files that carry concurrent assertions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("lbl failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("lbl failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("lbl failed");

`endif

### rtl/core/pdsr_pkg.sv
// Package for the point distance sort core: command/status types and constants.
// No dependencies.
`timescale 1ns / 1ps

package pdsr_pkg;

   localparam int KEY_W = 32;

   typedef struct packed {
      logic       capture;
      logic       sq_en;
      logic [1:0] sq_sel;
      logic       store;
      logic       drop;
      logic       sort_start;
      logic       cmp;
      logic       rank_wr;
      logic       addr_from_order;
      logic       med_latch;
      logic       out_load;
      logic       out_next;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic last;
      logic j_last;
      logic i_last;
      logic k_last;
      logic rsp_fire;
   } status_type;

   localparam logic [1:0] SEL_X = 2'd0;
   localparam logic [1:0] SEL_Y = 2'd1;
   localparam logic [1:0] SEL_Z = 2'd2;

endpackage

### rtl/core/pdsr_ctrl.sv
// Controller for the point distance sort core: load, rank, median and drain sequencing.
// Depends on pdsr_pkg.
`timescale 1ns / 1ps

module pdsr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   output logic                 req_ready,
   input  pdsr_pkg::status_type status,
   output pdsr_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SQX    = 4'd1;
   localparam logic [3:0] S_SQY    = 4'd2;
   localparam logic [3:0] S_SQZ    = 4'd3;
   localparam logic [3:0] S_STORE  = 4'd4;
   localparam logic [3:0] S_RK_RD  = 4'd5;
   localparam logic [3:0] S_RK_CMP = 4'd6;
   localparam logic [3:0] S_RK_WR  = 4'd7;
   localparam logic [3:0] S_MD_W1  = 4'd8;
   localparam logic [3:0] S_MD_W2  = 4'd9;
   localparam logic [3:0] S_MD_USE = 4'd10;
   localparam logic [3:0] S_OT_W1  = 4'd11;
   localparam logic [3:0] S_OT_W2  = 4'd12;
   localparam logic [3:0] S_OT_LD  = 4'd13;
   localparam logic [3:0] S_OT_HLD = 4'd14;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.capture = 1'b1;
               if (!status.full) begin
                  state_in = S_SQX;
               end else begin
                  cmd.drop = 1'b1;
                  if (status.last) begin
                     cmd.sort_start = 1'b1;
                     state_in = S_RK_RD;
                  end
               end
            end
         end
         S_SQX: begin
            cmd.sq_en = 1'b1;
            cmd.sq_sel = pdsr_pkg::SEL_X;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.sq_en = 1'b1;
            cmd.sq_sel = pdsr_pkg::SEL_Y;
            state_in = S_SQZ;
         end
         S_SQZ: begin
            cmd.sq_en = 1'b1;
            cmd.sq_sel = pdsr_pkg::SEL_Z;
            state_in = S_STORE;
         end
         S_STORE: begin
            cmd.store = 1'b1;
            if (status.last) begin
               cmd.sort_start = 1'b1;
               state_in = S_RK_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RK_RD: begin
            state_in = S_RK_CMP;
         end
         S_RK_CMP: begin
            cmd.cmp = 1'b1;
            state_in = status.j_last ? S_RK_WR : S_RK_RD;
         end
         S_RK_WR: begin
            cmd.rank_wr = 1'b1;
            state_in = status.i_last ? S_MD_W1 : S_RK_RD;
         end
         S_MD_W1: begin
            cmd.addr_from_order = 1'b1;
            state_in = S_MD_W2;
         end
         S_MD_W2: begin
            cmd.addr_from_order = 1'b1;
            state_in = S_MD_USE;
         end
         S_MD_USE: begin
            cmd.addr_from_order = 1'b1;
            cmd.med_latch = 1'b1;
            state_in = S_OT_W1;
         end
         S_OT_W1: begin
            cmd.addr_from_order = 1'b1;
            state_in = S_OT_W2;
         end
         S_OT_W2: begin
            cmd.addr_from_order = 1'b1;
            state_in = S_OT_LD;
         end
         S_OT_LD: begin
            cmd.addr_from_order = 1'b1;
            cmd.out_load = 1'b1;
            state_in = S_OT_HLD;
         end
         S_OT_HLD: begin
            cmd.addr_from_order = 1'b1;
            if (status.rsp_fire) begin
               if (status.k_last) begin
                  cmd.finish = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in = S_OT_W1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/pdsr_datapath.sv
// Datapath for the point distance sort core: point memory, squaring unit,
// rank counter, order memory, median and result register. Depends on pdsr_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdsr_datapath #(
   parameter int MAX_POINTS = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pdsr_pkg::cmd_type             cmd,
   output pdsr_pkg::status_type          status,
   input  logic [3*COORD_BITS-1:0]       in_data,
   input  logic                          in_last,
   output logic [6*COORD_BITS+34:0]      out_data,
   output logic [1:0]                    out_user,
   output logic                          out_last,
   output logic                          out_valid,
   input  logic                          out_ready
);

   localparam int C     = COORD_BITS;
   localparam int KW    = pdsr_pkg::KEY_W;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int ACC_W = 2 * C + 2;
   localparam int PT_W  = KW + 3 * C;

   logic [PT_W-1:0]  pt_mem [0:MAX_POINTS-1];
   logic [IDX_W-1:0] ord_mem [0:MAX_POINTS-1];

   logic [C-1:0]       x_ff, y_ff, z_ff;
   logic               last_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               drop_ff;
   logic [IDX_W-1:0]   i_ff, j_ff, rank_ff, k_ff;
   logic [PT_W-1:0]    pa_ff, pb_ff;
   logic [IDX_W-1:0]   ord_ff;
   logic [C-1:0]       mx_ff, my_ff, mz_ff;
   logic [6*C+34:0]    od_ff;
   logic [1:0]         ou_ff;
   logic               ol_ff;
   logic               ov_ff;

   logic [C-1:0]          sq_op;
   logic signed [2*C-1:0] sq_prod;
   logic [ACC_W+KW-1:0]   acc_ext;
   logic [KW-1:0]         key;
   logic [IDX_W-1:0]      wr_idx, addr_a, n_last, n_half;
   logic [KW-1:0]         key_a, key_b;
   logic                  before_i;
   logic [C:0]            mv_x, mv_y, mv_z;
   logic                  fire;

   assign wr_idx = cnt_ff[IDX_W-1:0];
   assign n_last = IDX_W'(cnt_ff - CNT_W'(1));
   assign n_half = IDX_W'(cnt_ff >> 1);

   always_comb begin
      case (cmd.sq_sel)
         pdsr_pkg::SEL_X: sq_op = x_ff;
         pdsr_pkg::SEL_Y: sq_op = y_ff;
         pdsr_pkg::SEL_Z: sq_op = z_ff;
         default:         sq_op = '0;
      endcase
   end

   assign sq_prod = $signed(sq_op) * $signed(sq_op);
   assign acc_ext = {{KW{1'b0}}, acc_ff};
   assign key     = (|acc_ext[ACC_W+KW-1:KW]) ? '1 : acc_ext[KW-1:0];

   assign addr_a = cmd.addr_from_order ? ord_ff : i_ff;
   assign key_a  = pa_ff[PT_W-1:3*C];
   assign key_b  = pb_ff[PT_W-1:3*C];
   assign before_i = (key_b < key_a) || ((key_b == key_a) && (j_ff > i_ff));

   assign mv_x = $signed({pa_ff[C-1], pa_ff[C-1:0]}) - $signed({mx_ff[C-1], mx_ff});
   assign mv_y = $signed({pa_ff[2*C-1], pa_ff[2*C-1:C]}) - $signed({my_ff[C-1], my_ff});
   assign mv_z = $signed({pa_ff[3*C-1], pa_ff[3*C-1:2*C]}) - $signed({mz_ff[C-1], mz_ff});

   assign fire = ov_ff & out_ready;

   assign status.full     = (cnt_ff == CNT_W'(MAX_POINTS));
   assign status.last     = cmd.capture ? in_last : last_ff;
   assign status.j_last   = (j_ff == n_last);
   assign status.i_last   = (i_ff == n_last);
   assign status.k_last   = (k_ff == n_last);
   assign status.rsp_fire = fire;

   assign out_data  = od_ff;
   assign out_user  = ou_ff;
   assign out_last  = ol_ff;
   assign out_valid = ov_ff;

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         pt_mem[wr_idx] <= {key, z_ff, y_ff, x_ff};
      end
      if (cmd.rank_wr) begin
         ord_mem[rank_ff] <= i_ff;
      end
      pa_ff  <= pt_mem[addr_a];
      pb_ff  <= pt_mem[j_ff];
      ord_ff <= ord_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff    <= in_data[C-1:0];
         y_ff    <= in_data[2*C-1:C];
         z_ff    <= in_data[3*C-1:2*C];
         last_ff <= in_last;
         acc_ff  <= '0;
      end else if (cmd.sq_en) begin
         acc_ff <= acc_ff + ACC_W'($unsigned(sq_prod));
      end
      if (cmd.med_latch) begin
         mx_ff <= pa_ff[C-1:0];
         my_ff <= pa_ff[2*C-1:C];
         mz_ff <= pa_ff[3*C-1:2*C];
      end
      if (cmd.out_load) begin
         od_ff <= {mv_z, mv_y, mv_x, pa_ff};
         ou_ff <= {drop_ff, k_ff == n_half};
         ol_ff <= (k_ff == n_last);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         drop_ff <= 1'b0;
         i_ff    <= '0;
         j_ff    <= '0;
         rank_ff <= '0;
         k_ff    <= '0;
         ov_ff   <= 1'b0;
      end else begin
         if (cmd.store) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.drop) begin
            drop_ff <= 1'b1;
         end
         if (cmd.sort_start) begin
            i_ff    <= '0;
            j_ff    <= '0;
            rank_ff <= '0;
         end
         if (cmd.cmp) begin
            rank_ff <= rank_ff + IDX_W'(before_i);
            if (!status.j_last) begin
               j_ff <= j_ff + IDX_W'(1);
            end
         end
         if (cmd.rank_wr) begin
            i_ff    <= i_ff + IDX_W'(1);
            j_ff    <= '0;
            rank_ff <= '0;
            k_ff    <= status.i_last ? n_half : k_ff;
         end
         if (cmd.med_latch) begin
            k_ff <= '0;
         end
         if (cmd.out_next) begin
            k_ff <= k_ff + IDX_W'(1);
         end
         if (cmd.out_load) begin
            ov_ff <= 1'b1;
         end else if (fire) begin
            ov_ff <= 1'b0;
         end
         if (cmd.finish) begin
            cnt_ff  <= '0;
            drop_ff <= 1'b0;
         end
      end
   end

   `ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(MAX_POINTS))
   `ASSERT_IMPL(a_out_nonempty, clock, reset, ov_ff, cnt_ff != '0)
   `ASSERT_IMPL(a_rank_bound, clock, reset, cmd.cmp, CNT_W'(rank_ff) < cnt_ff)
   `ASSERT_NEXT(a_finish_clear, clock, reset, cmd.finish, cnt_ff == '0 && !drop_ff)

endmodule

### rtl/core/point_distance_sort_recenter.sv
// Top level of the point distance sort core: controller plus datapath.
// Depends on pdsr_pkg, pdsr_ctrl and pdsr_datapath.
//
//  channel | dir | handshake          | contents
//  req     | in  | req_tvalid/tready  | one point; tlast ends the set
//  rsp     | out | rsp_tvalid/tready  | one sorted point with offsets and flags
//
// Load: each stored point steps through capture, three squares through one
// multiplier and store; a dropped point is only captured.
// Sort: each key pair is read, then compared; each point's rank is then written.
// Median lookup follows. Drain: each result is read, loaded and held until rsp_tready takes it.
// Reset is synchronous and active high; no request is taken while a set is sorted
// or drained, and a stalled result holds in the output register.
`timescale 1ns / 1ps

module point_distance_sort_recenter #(
   parameter int MAX_POINTS = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // coord_x, coord_y, coord_z, zero pad
   input  logic [((3*COORD_BITS+7)/8)*8-1:0]             req_tdata,
   input  logic                                          req_tlast,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // sorted_x, sorted_y, sorted_z, dist_squared, moved_x, moved_y, moved_z, zero pad
   output logic [((6*COORD_BITS+35+7)/8)*8-1:0]          rsp_tdata,
   // is_median, overflowed
   output logic [1:0]                                    rsp_tuser,
   output logic                                          rsp_tlast
);

   localparam int OUT_W = 6 * COORD_BITS + 35;
   localparam int OUT_T = ((OUT_W + 7) / 8) * 8;

   pdsr_pkg::cmd_type    cmd;
   pdsr_pkg::status_type status;
   logic [OUT_W-1:0]     out_data;
   logic                 req_fire;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_tdata = OUT_T'(out_data);

   pdsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   pdsr_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_data   (req_tdata[3*COORD_BITS-1:0]),
      .in_last   (req_tlast),
      .out_data  (out_data),
      .out_user  (rsp_tuser),
      .out_last  (rsp_tlast),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready)
   );

endmodule

### sim/tb_point_distance_sort_recenter.sv
// Testbench for point_distance_sort_recenter: sends point sets, predicts sorted
// results with offsets from the median, and compares every result field by field.
// Depends on the point_distance_sort_recenter RTL only.
`timescale 1ns / 1ps

module tb_point_distance_sort_recenter;

   localparam int MAX_PTS = 16;
   localparam int CB = 16;
   localparam int REQ_W = ((3*CB+7)/8)*8;
   localparam int RSP_W = ((6*CB+35+7)/8)*8;

   typedef struct packed {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
      logic [31:0]        key;
      logic signed [16:0] mx;
      logic signed [16:0] my;
      logic signed [16:0] mz;
      logic               med;
      logic               ovf;
      logic               lst;
   } sorted_point_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   point_distance_sort_recenter #(.MAX_POINTS(MAX_PTS), .COORD_BITS(CB)) dut (.*);

   sorted_point_type expected_points[$];
   logic signed [15:0] set_x[MAX_PTS], set_y[MAX_PTS], set_z[MAX_PTS];
   logic [31:0] set_key[MAX_PTS];
   int set_count = 0;
   bit set_dropped = 0;
   int error_count = 0;
   longint cycle_count = 0;

   initial forever #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic logic [31:0] square_sum(logic signed [15:0] x, y, z);
      logic [33:0] s;
      s = 34'(32'(x) * 32'(x)) + 34'(32'(y) * 32'(y)) + 34'(32'(z) * 32'(z));
      return (s > 34'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
   endfunction

   // Store the point and, at the end of a set, queue the sorted results.
   task automatic predict_point(logic signed [15:0] x, y, z, bit fin);
      int ord[MAX_PTS];
      int n, cur, j, med;
      sorted_point_type r;
      if (set_count < MAX_PTS) begin
         set_x[set_count] = x; set_y[set_count] = y; set_z[set_count] = z;
         set_key[set_count] = square_sum(x, y, z);
         set_count++;
      end else set_dropped = 1;
      if (!fin) return;
      n = set_count;
      for (int i = 0; i < n; i++) ord[i] = n - 1 - i;
      for (int i = 1; i < n; i++) begin
         cur = ord[i];
         j = i;
         while (j > 0 && set_key[ord[j-1]] > set_key[cur]) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = cur;
      end
      med = ord[n/2];
      for (int i = 0; i < n; i++) begin
         r.px = set_x[ord[i]]; r.py = set_y[ord[i]]; r.pz = set_z[ord[i]];
         r.key = set_key[ord[i]];
         r.mx = 17'(set_x[ord[i]]) - 17'(set_x[med]);
         r.my = 17'(set_y[ord[i]]) - 17'(set_y[med]);
         r.mz = 17'(set_z[ord[i]]) - 17'(set_z[med]);
         r.med = (i == n/2); r.ovf = set_dropped; r.lst = (i == n-1);
         expected_points.push_back(r);
      end
      set_count = 0;
      set_dropped = 0;
   endtask

   task automatic send_point(logic signed [15:0] x, y, z, bit fin, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {z, y, x};
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      predict_point(x, y, z, fin);
   endtask

   task automatic release_bus();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   // Receiver: draw a stall per result (none while sink_bursty), accept and compare.
   bit sink_bursty = 0;
   initial begin
      sorted_point_type e;
      int stall;
      @(negedge reset);
      forever begin
         stall = sink_bursty ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_points.size() == 0) report_mismatch("result with none expected");
         else begin
            e = expected_points.pop_front();
            if (rsp_tdata[15:0] !== e.px) report_mismatch("sorted_x");
            if (rsp_tdata[31:16] !== e.py) report_mismatch("sorted_y");
            if (rsp_tdata[47:32] !== e.pz) report_mismatch("sorted_z");
            if (rsp_tdata[79:48] !== e.key) report_mismatch("dist_squared");
            if (rsp_tdata[96:80] !== e.mx) report_mismatch("moved_x");
            if (rsp_tdata[113:97] !== e.my) report_mismatch("moved_y");
            if (rsp_tdata[130:114] !== e.mz) report_mismatch("moved_z");
            if (rsp_tuser[0] !== e.med) report_mismatch("is_median");
            if (rsp_tuser[1] !== e.ovf) report_mismatch("overflowed");
            if (rsp_tlast !== e.lst) report_mismatch("last_result");
         end
      end
   end

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($urandom_range(0, 6)) - 16'sd3;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_extremes();
      send_point(16'sh8000, 16'sh8000, 16'sh8000, 1);
      send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
      send_point(16'sh8000, 16'sh7FFF, 0, 0);
      send_point(0, 0, 0, 0);
      send_point(16'shFFFF, 1, 16'sh5555, 1);
      release_bus();
   endtask

   task automatic test_ties();
      // equal keys come out latest arrival first
      send_point(3, 4, 0, 0);
      send_point(0, 3, 4, 0);
      send_point(4, 0, 3, 0);
      send_point(-3, -4, 0, 1);
      release_bus();
   endtask

   task automatic test_overflow();
      for (int i = 0; i < MAX_PTS + 3; i++)
         send_point(16'(i*37 - 300), 16'(-i), 16'(i*i), i == MAX_PTS + 2);
      for (int i = 0; i < MAX_PTS; i++)
         send_point(rand_coord(), rand_coord(), rand_coord(), i == MAX_PTS - 1);
      release_bus();
   endtask

   task automatic test_random(int items);
      int sent, n;
      sent = 0;
      while (sent < items) begin
         sink_bursty = ($urandom_range(0, 3) == 0);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 12);
         for (int i = 0; i < n; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == n - 1, sink_bursty);
         sent += n;
      end
      release_bus();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      test_extremes();
      test_ties();
      test_overflow();
      test_random(270);
      wait (expected_points.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
